@@ rtl/core/pipas_pkg.sv @@
// Shared types and constants for the point-in-polygon angle-sum block.
package pipas_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int ZW           = 32;

    // Step angles atan(2^-i), 2^32 units per turn.
    function automatic logic [ZW-1:0] step_angle(input logic [4:0] i);
        logic [ZW-1:0] a;
        begin
            case (i)
                5'd0:  a = 32'h20000000;
                5'd1:  a = 32'h12E4051E;
                5'd2:  a = 32'h09FB385B;
                5'd3:  a = 32'h051111D4;
                5'd4:  a = 32'h028B0D43;
                5'd5:  a = 32'h0145D7E1;
                5'd6:  a = 32'h00A2F61E;
                5'd7:  a = 32'h00517C55;
                5'd8:  a = 32'h0028BE53;
                5'd9:  a = 32'h00145F2F;
                5'd10: a = 32'h000A2F98;
                5'd11: a = 32'h000517CC;
                5'd12: a = 32'h00028BE6;
                5'd13: a = 32'h000145F3;
                5'd14: a = 32'h0000A2FA;
                5'd15: a = 32'h0000517D;
                5'd16: a = 32'h000028BE;
                5'd17: a = 32'h0000145F;
                5'd18: a = 32'h00000A30;
                5'd19: a = 32'h00000518;
                5'd20: a = 32'h0000028C;
                5'd21: a = 32'h00000146;
                5'd22: a = 32'h000000A3;
                5'd23: a = 32'h00000051;
                default: a = '0;
            endcase
            return a;
        end
    endfunction

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [0:0] REG_VERTEX_COUNT = 1'b0;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_RD    = 7'b0000010,
        ST_EDGE  = 7'b0000100,
        ST_ANG_S = 7'b0001000,
        ST_ANG_T = 7'b0010000,
        ST_NEXT  = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

endpackage

@@ rtl/core/pipas_cordic.sv @@
// Iterative CORDIC vectoring unit: one step a cycle, binary angle out.
module pipas_cordic
    import pipas_pkg::*;
#(
    parameter int DW = 34,
    parameter int AB = 16
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [DW-1:0] dx,
    input  logic signed [DW-1:0] dy,
    output logic                 done,
    output logic [AB-1:0]        angle
);
    localparam int XW = DW + 18;

    logic signed [XW-1:0] x_reg, x_next, y_reg, y_next;
    logic [ZW-1:0]        z_reg, z_next;
    logic [4:0]           i_reg, i_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic signed [XW-1:0] xs, ys, x0, y0;
    logic [ZW-1:0]        zr;

    always_comb
    begin
        x0 = XW'(dx) <<< 16;
        y0 = XW'(dy) <<< 16;
        xs = x_reg >>> i_reg;
        ys = y_reg >>> i_reg;
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        i_next = i_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            i_next = '0;
            if (x0 < 0)
            begin
                if (y0 >= 0)
                begin
                    x_next = y0; y_next = -x0; z_next = 32'h40000000;
                end
                else
                begin
                    x_next = -y0; y_next = x0; z_next = 32'hC0000000;
                end
            end
            else
            begin
                x_next = x0; y_next = y0; z_next = '0;
            end
        end
        else if (busy_reg)
        begin
            if (y_reg >= 0)
            begin
                x_next = x_reg + ys; y_next = y_reg - xs;
                z_next = z_reg + step_angle(i_reg);
            end
            else
            begin
                x_next = x_reg - ys; y_next = y_reg + xs;
                z_next = z_reg - step_angle(i_reg);
            end
            i_next = i_reg + 5'd1;
            if (i_reg == 5'(CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        i_reg <= i_next;
    end

    assign zr    = z_reg + (ZW'(1) << (31 - AB));
    assign angle = zr[ZW-1 -: AB];
    assign done  = done_reg;
endmodule

@@ rtl/core/pipas_edge.sv @@
// Exact on-edge test for one edge against the query point, two stages.
module pipas_edge #(
    parameter int CW = 24
)(
    input  logic                 clk,
    input  logic signed [CW-1:0] px,
    input  logic signed [CW-1:0] py,
    input  logic signed [CW-1:0] sx,
    input  logic signed [CW-1:0] sy,
    input  logic signed [CW-1:0] tx,
    input  logic signed [CW-1:0] ty,
    output logic                 hit
);
    localparam int DW = CW + 1;

    logic signed [DW-1:0] a_reg [0:5];
    logic signed [2*DW-1:0] p1_reg, p2_reg;
    logic signed [2*DW-1:0] q1_reg, q2_reg;

    always_ff @(posedge clk)
    begin
        a_reg[0] <= DW'(sx) - DW'(px);
        a_reg[1] <= DW'(px) - DW'(tx);
        a_reg[2] <= DW'(sy) - DW'(py);
        a_reg[3] <= DW'(py) - DW'(ty);
        a_reg[4] <= DW'(ty) - DW'(sy);
        a_reg[5] <= DW'(tx) - DW'(sx);
        p1_reg <= (2*DW)'(a_reg[0]) * (2*DW)'(a_reg[1]);
        p2_reg <= (2*DW)'(a_reg[2]) * (2*DW)'(a_reg[3]);
        q1_reg <= (2*DW)'(-a_reg[0]) * (2*DW)'(a_reg[4]);
        q2_reg <= (2*DW)'(-a_reg[2]) * (2*DW)'(a_reg[5]);
    end

    assign hit = (p1_reg >= 0) && (p2_reg >= 0) && (q1_reg == q2_reg);
endmodule

@@ rtl/core/point_in_polygon_angle_sum.sv @@
// Top level of the point-in-polygon angle-sum block.
//
// Vertices live in one synchronous memory (one write port, one read port,
// registered read). A write beat stores a vertex. A query walks the edges:
// for each vertex it reads the entry and its predecessor, runs the exact
// on-edge test, then two CORDIC angles on a shared 24-step iterative unit,
// and advances to the next vertex. The cost per vertex is dominated by the
// CORDIC unit; a boundary hit ends the walk when the on-edge test of the
// hitting vertex reports it. With vertex_count zero the query skips the
// walk and the result is registered from ST_DONE. The result waits in an
// output register and holds until the beat is taken; no input beat is
// taken while a walk runs or a result waits.
module point_in_polygon_angle_sum
    import pipas_pkg::*;
#(
    parameter int MAX_VERTICES = 256,
    parameter int COORD_BITS   = 24,
    parameter int ANGLE_BITS   = 16
)(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [1:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         req_type,
    input  logic [7:0]                   vertex_index,
    input  logic signed [COORD_BITS-1:0] coord_x,
    input  logic signed [COORD_BITS-1:0] coord_y,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         inside_res,
    output logic                         on_boundary
);
    localparam int AW = $clog2(MAX_VERTICES);
    localparam int NW = $clog2(MAX_VERTICES + 1);
    localparam int DW = COORD_BITS + 1;
    localparam int SW = ANGLE_BITS + NW + 1;

    // vertex memory
    logic [2*COORD_BITS-1:0] mem [0:MAX_VERTICES-1];
    logic [2*COORD_BITS-1:0] rd_data_reg;
    logic [AW-1:0]           rd_addr;

    logic [8:0]    count_reg;
    logic [NW-1:0] cnt_eff;
    state_t        state_reg, state_next;
    logic [NW-1:0] m_reg, m_next;
    logic [1:0]    sub_reg, sub_next;
    logic signed [COORD_BITS-1:0] px_reg, py_reg, sx_reg, sy_reg, tx_reg, ty_reg;
    logic [ANGLE_BITS-1:0] as_reg;
    logic signed [SW-1:0] sum_reg, sum_next;
    logic out_valid_reg, out_valid_next;
    logic ins_reg, ins_next, bnd_reg, bnd_next;

    logic cfg_wr, acc;
    logic edge_hit, c_start, c_done;
    logic signed [DW-1:0] c_dx, c_dy;
    logic [ANGLE_BITS-1:0] c_ang, d;
    logic signed [SW-1:0] sabs;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[1:0] == {REG_VERTEX_COUNT, 1'b0});
    assign prdata = (paddr == {REG_VERTEX_COUNT, 1'b0}) ? {23'd0, count_reg} : 32'd0;
    assign cnt_eff = (int'(count_reg) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(count_reg);

    assign in_ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign acc = in_valid && in_ready;

    always_ff @(posedge clk)
    begin
        if (acc && req_type == REQ_WRITE && int'(vertex_index) < MAX_VERTICES)
            mem[AW'(vertex_index)] <= {coord_x, coord_y};
        rd_data_reg <= mem[rd_addr];
    end

    // sub_reg 0: read current, 1: read previous, 2: capture previous
    always_comb
    begin
        if (sub_reg == 2'd0)
            rd_addr = AW'(m_reg);
        else
            rd_addr = (m_reg == '0) ? AW'(cnt_eff - NW'(1)) : AW'(m_reg - NW'(1));
    end

    pipas_edge #(.CW(COORD_BITS)) u_edge (
        .clk(clk), .px(px_reg), .py(py_reg), .sx(sx_reg), .sy(sy_reg),
        .tx(tx_reg), .ty(ty_reg), .hit(edge_hit)
    );

    assign c_start = ((state_reg == ST_EDGE) && (sub_reg == 2'd3) && !edge_hit)
                     || ((state_reg == ST_ANG_S) && c_done);
    assign c_dx = (state_reg == ST_EDGE) ? DW'(sx_reg) - DW'(px_reg)
                                         : DW'(tx_reg) - DW'(px_reg);
    assign c_dy = (state_reg == ST_EDGE) ? DW'(sy_reg) - DW'(py_reg)
                                         : DW'(ty_reg) - DW'(py_reg);

    pipas_cordic #(.DW(DW), .AB(ANGLE_BITS)) u_cordic (
        .clk(clk), .rst_n(rst_n), .start(c_start), .dx(c_dx), .dy(c_dy),
        .done(c_done), .angle(c_ang)
    );

    assign d    = as_reg - c_ang;
    assign sabs = (sum_reg < 0) ? -sum_reg : sum_reg;

    always_comb
    begin
        state_next = state_reg;
        m_next = m_reg;
        sub_next = sub_reg;
        sum_next = sum_reg;
        out_valid_next = out_valid_reg;
        ins_next = ins_reg;
        bnd_next = bnd_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc && req_type == REQ_QUERY)
                begin
                    m_next = '0;
                    sub_next = '0;
                    sum_next = '0;
                    if (cnt_eff == '0)
                        state_next = ST_DONE;
                    else
                        state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                sub_next = sub_reg + 2'd1;
                if (sub_reg == 2'd2)
                begin
                    sub_next = '0;
                    state_next = ST_EDGE;
                end
            end
            ST_EDGE:
            begin
                sub_next = sub_reg + 2'd1;
                if (sub_reg == 2'd3)
                begin
                    sub_next = '0;
                    if (edge_hit)
                    begin
                        ins_next = 1'b1;
                        bnd_next = 1'b1;
                        out_valid_next = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                        state_next = ST_ANG_S;
                end
            end
            ST_ANG_S:
            begin
                if (c_done)
                    state_next = ST_ANG_T;
            end
            ST_ANG_T:
            begin
                if (c_done)
                begin
                    sum_next = sum_reg + SW'($signed(d));
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                m_next = m_reg + NW'(1);
                if (m_reg + NW'(1) == cnt_eff)
                begin
                    ins_next = (sabs >= SW'(1 << (ANGLE_BITS - 2)));
                    bnd_next = 1'b0;
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                    state_next = ST_RD;
            end
            ST_DONE:
            begin
                ins_next = 1'b0;
                bnd_next = 1'b0;
                out_valid_next = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            out_valid_reg <= 1'b0;
            sub_reg <= '0;
            m_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            sub_reg <= sub_next;
            m_reg <= m_next;
            if (cfg_wr)
                count_reg <= pwdata[8:0];
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        ins_reg <= ins_next;
        bnd_reg <= bnd_next;
        if (acc)
        begin
            px_reg <= coord_x;
            py_reg <= coord_y;
        end
        // hold the current vertex, then the previous one
        if (state_reg == ST_RD && sub_reg == 2'd1)
        begin
            sx_reg <= rd_data_reg[2*COORD_BITS-1 -: COORD_BITS];
            sy_reg <= rd_data_reg[COORD_BITS-1:0];
        end
        if (state_reg == ST_RD && sub_reg == 2'd2)
        begin
            tx_reg <= rd_data_reg[2*COORD_BITS-1 -: COORD_BITS];
            ty_reg <= rd_data_reg[COORD_BITS-1:0];
        end
        if (state_reg == ST_ANG_S && c_done)
            as_reg <= c_ang;
    end

    assign out_valid   = out_valid_reg;
    assign inside_res  = ins_reg;
    assign on_boundary = bnd_reg;

    a_bnd_inside: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && on_boundary |-> inside_res)
        else $error("boundary result without inside");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ready)
        else $error("input taken during a walk");
    a_cordic_start: assert property (@(posedge clk) disable iff (!rst_n)
        c_start |-> (state_reg == ST_EDGE || state_reg == ST_ANG_S))
        else $error("stray angle start");
endmodule
